@@ rtl/core/f32mt_pkg.sv @@
// ----------------------------------------------------------------------------
// f32mt_pkg
// shared types and constants for the truncating binary32 multiplier
// ----------------------------------------------------------------------------
package f32mt_pkg;

  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = 24;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned SumW  = 9;
  localparam int unsigned ProdW = 48;

  localparam logic [31:0]     QnanBits = 32'h7FC0_0000;
  localparam logic [ExpW-1:0] ExpMax   = 8'hFF;
  localparam logic [SumW-1:0] Bias     = 9'd127;
  localparam logic [SumW-1:0] OvfSum   = 9'd382;

  // special-case result decided in the first stage
  typedef enum logic [2:0] {
    SPC_NONE = 3'b000,
    SPC_NAN  = 3'b001,
    SPC_INF  = 3'b010,
    SPC_ZERO = 3'b011,
    SPC_OVF  = 3'b100,
    SPC_UNF  = 3'b101
  } spc_t;

  // stage 1 -> stage 2 payload
  typedef struct packed {
    logic            sign;
    spc_t            spc;
    logic [SumW-1:0] expo;
    logic [SigW-1:0] sig_a;
    logic [SigW-1:0] sig_b;
  } dec_t;

  // stage 2 -> stage 3 payload
  typedef struct packed {
    logic             sign;
    spc_t             spc;
    logic [SumW-1:0]  expo;
    logic [ProdW-1:0] prod;
  } mul_t;

  // result payload
  typedef struct packed {
    logic        unf;
    logic        ovf;
    logic        inv;
    logic [31:0] bits;
  } res_t;

endpackage

@@ rtl/core/f32mt_decode.sv @@
// ----------------------------------------------------------------------------
// f32mt_decode
// classifies operands, forms exponent sum and significands
// ----------------------------------------------------------------------------
module f32mt_decode
  import f32mt_pkg::*;
(
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output dec_t        dec
);

  logic [ExpW-1:0]  ea, eb;
  logic [FracW-1:0] fa, fb;
  logic a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [SumW-1:0] sum9;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    fa = operand_a[22:0];
    fb = operand_b[22:0];
    a_zero = (ea == '0) && (fa == '0);
    b_zero = (eb == '0) && (fb == '0);
    a_inf  = (ea == ExpMax) && (fa == '0);
    b_inf  = (eb == ExpMax) && (fb == '0);
    a_nan  = (ea == ExpMax) && (fa != '0);
    b_nan  = (eb == ExpMax) && (fb != '0);
    sum9   = {1'b0, ea} + {1'b0, eb};

    dec.sign  = operand_a[31] ^ operand_b[31];
    dec.expo  = sum9 - Bias;
    dec.sig_a = {(ea != '0), fa};
    dec.sig_b = {(eb != '0), fb};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      dec.spc = SPC_NAN;
    end else if (a_inf || b_inf) begin
      dec.spc = SPC_INF;
    end else if (a_zero || b_zero) begin
      dec.spc = SPC_ZERO;
    end else if (sum9 >= OvfSum) begin
      dec.spc = SPC_OVF;
    end else if (sum9 < Bias) begin
      dec.spc = SPC_UNF;
    end else begin
      dec.spc = SPC_NONE;
    end
  end

endmodule

@@ rtl/core/f32mt_pack.sv @@
// ----------------------------------------------------------------------------
// f32mt_pack
// normalizes by one bit, truncates and packs result with flags
// ----------------------------------------------------------------------------
module f32mt_pack
  import f32mt_pkg::*;
(
  input  mul_t mul,
  output res_t res
);

  logic             high;
  logic [SumW-1:0]  expo;
  logic [FracW-1:0] frac;

  always_comb begin
    high = mul.prod[ProdW-1];
    expo = mul.expo + {{(SumW-1){1'b0}}, high};
    frac = high ? mul.prod[ProdW-2 -: FracW] : mul.prod[ProdW-3 -: FracW];
    res  = '0;
    case (mul.spc)
      SPC_NAN: begin
        res.bits = QnanBits;
        res.inv  = 1'b1;
      end
      SPC_INF:  res.bits = {mul.sign, ExpMax, {FracW{1'b0}}};
      SPC_ZERO: res.bits = {mul.sign, 31'd0};
      SPC_OVF: begin
        res.bits = {mul.sign, ExpMax, {FracW{1'b0}}};
        res.ovf  = 1'b1;
      end
      SPC_UNF: begin
        res.bits = {mul.sign, 31'd0};
        res.unf  = 1'b1;
      end
      default: begin
        if (expo == '0) begin
          res.bits = {mul.sign, 31'd0};
          res.unf  = 1'b1;
        end else if (expo >= {1'b0, ExpMax}) begin
          res.bits = {mul.sign, ExpMax, {FracW{1'b0}}};
          res.ovf  = 1'b1;
        end else begin
          res.bits = {mul.sign, expo[ExpW-1:0], frac};
        end
      end
    endcase
  end

endmodule

@@ rtl/core/float32_multiply_truncating.sv @@
// ----------------------------------------------------------------------------
// float32_multiply_truncating
// pipelined binary32 multiplier, truncated fraction, three flags
// ----------------------------------------------------------------------------
// usage:
//   in_* carries an operand pair, out_* the product pattern and its flags.
//   an item moves when tvalid and tready are both high.
// pipeline:
//   stage 1 decodes operands and special cases, stage 2 holds the 24x24
//   significand product, stage 3 normalizes and packs into the output register.
//   out_tvalid rises once the item has passed all three register stages, the
//   first loaded at the accepting edge; one item per cycle while not stalled.
// stalls:
//   the pipeline advances as a whole when the output register is empty or
//   being taken; while out_tready is low and the output is full, in_tready
//   is low and every stage holds its item, so nothing is lost or repeated.
// reset:
//   rst_n low clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module float32_multiply_truncating
  import f32mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // product_bits [31:0]
  output logic [2:0]  out_tuser   // invalid [0], overflow [1], underflow [2]
);

  logic v1_r, v2_r, v3_r;
  dec_t d1_r, dec;
  mul_t m2_r;
  res_t r3_r, res;
  logic adv;

  // whole pipe moves when the output slot is free or being taken
  assign adv       = !v3_r || out_tready;
  assign in_tready = adv;

  f32mt_decode u_dec (
    .operand_a (in_tdata[31:0]),
    .operand_b (in_tdata[63:32]),
    .dec       (dec)
  );

  f32mt_pack u_pack (
    .mul (m2_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r      <= dec;
      m2_r.sign <= d1_r.sign;
      m2_r.spc  <= d1_r.spc;
      m2_r.expo <= d1_r.expo;
      m2_r.prod <= ProdW'(d1_r.sig_a) * ProdW'(d1_r.sig_b);
      r3_r      <= res;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = r3_r.bits;
  assign out_tuser  = {r3_r.unf, r3_r.ovf, r3_r.inv};

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed during stall");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tuser) <= 1)
    else $error("more than one flag set");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 adv ##0 1 ##1 adv |=> out_tvalid)
    else $error("item lost in pipeline");
`endif

endmodule
